FILE: rtl/core/nvs_pkg.sv
package nvs_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int COORD_BITS   = 16;

    // Fixed widths of the stream fields.
    localparam int FIELD_W      = 16;
    localparam int IDX_OUT_W    = 10;
    localparam int DIST_OUT_W   = 34;
    localparam int TDATA_IN_W   = 48;
    localparam int TDATA_OUT_W  = 48;
    localparam int TUSER_IN_W   = 2;
    localparam int TUSER_OUT_W  = 2;

    localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int VTX_W        = 3 * COORD_BITS;
    localparam int SQ_W         = 2 * COORD_BITS;
    localparam int SUM_W        = SQ_W + 2;
    localparam int COORD_EXT_W  = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int IDX_EXT_W    = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
    localparam int DIST_EXT_W   = (SUM_W > DIST_OUT_W) ? SUM_W : DIST_OUT_W;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req_e;

    typedef struct packed {
        logic clr;
        logic wr;
        logic start;
        logic issue;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/core/nvs_ctrl.sv
module nvs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  nvs_pkg::t_req_e i_req,
    input  nvs_pkg::t_status i_status,
    output logic            o_ready,
    output nvs_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state_e;

    t_state_e r_state;
    t_state_e n_state;

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_req)
                        nvs_pkg::REQ_CLEAR: begin
                            o_cmd.clr = 1'b1;
                        end
                        nvs_pkg::REQ_APPEND: begin
                            o_cmd.wr = 1'b1;
                        end
                        nvs_pkg::REQ_QUERY: begin
                            o_cmd.start = 1'b1;
                            n_state = i_status.count_zero ? ST_DONE : ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/nvs_dp.sv
module nvs_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  nvs_pkg::t_cmd                      i_cmd,
    input  logic [nvs_pkg::TDATA_IN_W-1:0]     i_tdata,
    input  logic                               i_out_ready,
    output nvs_pkg::t_status                   o_status,
    output logic                               o_out_valid,
    output logic [nvs_pkg::TDATA_OUT_W-1:0]    o_out_data,
    output logic [nvs_pkg::TUSER_OUT_W-1:0]    o_out_user
);

    localparam int CB = nvs_pkg::COORD_BITS;

    function automatic logic [CB-1:0] coord_of(input logic [nvs_pkg::FIELD_W-1:0] f);
        logic signed [nvs_pkg::COORD_EXT_W-1:0] ext;
        ext = nvs_pkg::COORD_EXT_W'($signed(f));
        return ext[CB-1:0];
    endfunction

    function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a,
                                               input logic [CB-1:0] b);
        logic signed [CB:0] d;
        logic signed [CB:0] m;
        d = (CB+1)'($signed(a)) - (CB+1)'($signed(b));
        m = d[CB] ? -d : d;
        return m[CB-1:0];
    endfunction

    logic [nvs_pkg::VTX_W-1:0]  r_mem [nvs_pkg::MAX_VERTICES];
    logic [nvs_pkg::VTX_W-1:0]  r_rd;
    logic [nvs_pkg::CNT_W-1:0]  r_count;
    logic                       r_ovf;
    logic                       full;
    logic [nvs_pkg::VTX_W-1:0]  vtx_in;

    logic [CB-1:0]              r_px, r_py, r_pz;
    logic [nvs_pkg::IDX_W-1:0]  r_addr;

    logic                       r_v1, r_v2, r_v3, r_v4;
    logic [nvs_pkg::IDX_W-1:0]  r_i1, r_i2, r_i3, r_i4;
    logic [CB-1:0]              r_ax, r_ay, r_az;
    logic [nvs_pkg::SQ_W-1:0]   r_sx, r_sy, r_sz;
    logic [nvs_pkg::SUM_W-1:0]  r_sum;

    logic                       r_seen;
    logic [nvs_pkg::SUM_W-1:0]  r_best_d;
    logic [nvs_pkg::IDX_W-1:0]  r_best_i;

    logic                       r_out_valid;
    logic [nvs_pkg::IDX_OUT_W-1:0]  r_out_idx;
    logic [nvs_pkg::DIST_OUT_W-1:0] r_out_dist;
    logic                       r_out_empty;
    logic                       r_out_ovf;

    logic [nvs_pkg::IDX_EXT_W-1:0]  idx_ext;
    logic [nvs_pkg::DIST_EXT_W-1:0] dist_ext;

    assign full   = (r_count == nvs_pkg::CNT_W'(nvs_pkg::MAX_VERTICES));
    assign vtx_in = {coord_of(i_tdata[47:32]), coord_of(i_tdata[31:16]),
                     coord_of(i_tdata[15:0])};

    // Single write port for appends, one registered read per cycle for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && !full) begin
            r_mem[r_count[nvs_pkg::IDX_W-1:0]] <= vtx_in;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.clr) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.wr) begin
            if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + nvs_pkg::CNT_W'(1);
            end
        end
    end

    // Query point and read address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px   <= vtx_in[CB-1:0];
            r_py   <= vtx_in[2*CB-1:CB];
            r_pz   <= vtx_in[3*CB-1:2*CB];
            r_addr <= '0;
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + nvs_pkg::IDX_W'(1);
        end
    end

    // Distance pipeline: read, absolute difference, square, sum, compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1  <= r_addr;
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_i4  <= r_i3;
        r_ax  <= abs_diff(r_rd[CB-1:0], r_px);
        r_ay  <= abs_diff(r_rd[2*CB-1:CB], r_py);
        r_az  <= abs_diff(r_rd[3*CB-1:2*CB], r_pz);
        r_sx  <= nvs_pkg::SQ_W'(r_ax) * nvs_pkg::SQ_W'(r_ax);
        r_sy  <= nvs_pkg::SQ_W'(r_ay) * nvs_pkg::SQ_W'(r_ay);
        r_sz  <= nvs_pkg::SQ_W'(r_az) * nvs_pkg::SQ_W'(r_az);
        r_sum <= nvs_pkg::SUM_W'(r_sx) + nvs_pkg::SUM_W'(r_sy) + nvs_pkg::SUM_W'(r_sz);
    end

    // Strict less-than keeps the earliest index among equal distances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_cmd.start) begin
            r_seen <= 1'b0;
        end else if (r_v4) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_best_d <= '0;
            r_best_i <= '0;
        end else if (r_v4 && (!r_seen || (r_sum < r_best_d))) begin
            r_best_d <= r_sum;
            r_best_i <= r_i4;
        end
    end

    assign idx_ext  = nvs_pkg::IDX_EXT_W'(r_best_i);
    assign dist_ext = nvs_pkg::DIST_EXT_W'(r_best_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_idx   <= idx_ext[nvs_pkg::IDX_OUT_W-1:0];
            r_out_dist  <= dist_ext[nvs_pkg::DIST_OUT_W-1:0];
            r_out_empty <= (r_count == '0);
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.last_issue = (nvs_pkg::CNT_W'(r_addr) == r_count - nvs_pkg::CNT_W'(1));
    assign o_status.pipe_busy  = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = nvs_pkg::TDATA_OUT_W'({r_out_dist, r_out_idx});
    assign o_out_user  = {r_out_ovf, r_out_empty};

endmodule

FILE: rtl/core/nearest_vertex_search.sv
// Brute-force nearest vertex search over a store of up to 1024 vertices with signed
// 16-bit coordinates (8 fraction bits). Clear and append requests return nothing; an
// append to a full store is dropped and sets a sticky overflow flag. For a query, the
// store is one memory with a single read port, so the scan reads one vertex per cycle
// and then drains a four-stage distance pipeline (difference, square, sum, compare)
// before the result is placed in the output register. A query on an empty store skips
// the scan and loads its result directly. Input is accepted again as soon as the
// result sits in the output register.
module nearest_vertex_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // coord_x [15:0], coord_y [31:16], coord_z [47:32]
    input  logic [1:0]  s_axis_tuser,   // req_type [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // closest_index [9:0], best_distance [43:10], zero [47:44]
    output logic [1:0]  m_axis_tuser    // store_empty [0], store_overflowed [1]
);

    nvs_pkg::t_cmd    cmd;
    nvs_pkg::t_status status;

    nvs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_req    (nvs_pkg::t_req_e'(s_axis_tuser)),
        .i_status (status),
        .o_ready  (s_axis_tready),
        .o_cmd    (cmd)
    );

    nvs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_tdata     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

    // An empty store must report index zero and distance zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[43:0] == 44'd0))
        else $error("empty-store result carries nonzero index or distance");

    // Overflow needs a full store, so it can never be reported with an empty one.
    a_empty_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("overflow reported on an empty store");

    // A new result is only loaded from the final state, where input is held off.
    a_load_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result loaded while input side was ready");

    // Input is never taken while a scan is running.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.pipe_busy |-> !s_axis_tready)
        else $error("input ready during a scan");

endmodule

FILE: sim/testbench.sv
module testbench;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_ITEMS   = 580;

    typedef struct {
        logic [nvs_pkg::IDX_OUT_W-1:0]  near_idx;
        logic [nvs_pkg::DIST_OUT_W-1:0] distance;
        logic                           was_empty;
        logic                           had_drop;
    } t_answer;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [47:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;

    // Shadow copy of the vertex store kept by the predictor.
    logic signed [nvs_pkg::COORD_BITS-1:0] stored_x [0:nvs_pkg::MAX_VERTICES-1];
    logic signed [nvs_pkg::COORD_BITS-1:0] stored_y [0:nvs_pkg::MAX_VERTICES-1];
    logic signed [nvs_pkg::COORD_BITS-1:0] stored_z [0:nvs_pkg::MAX_VERTICES-1];
    int      stored_count = 0;
    bit      dropped_flag = 1'b0;
    t_answer pending_answers [$];

    int error_count = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left = 0;

    nearest_vertex_search uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < 100) begin
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        end
        error_count++;
    endtask

    function automatic void predict_request(input logic [1:0] req,
                                            input logic signed [15:0] px,
                                            input logic signed [15:0] py,
                                            input logic signed [15:0] pz);
        t_answer ans;
        longint  best;
        longint  d;
        longint  dx;
        longint  dy;
        longint  dz;
        int      best_i;
        case (req)
            nvs_pkg::REQ_CLEAR: begin
                stored_count = 0;
                dropped_flag = 1'b0;
            end
            nvs_pkg::REQ_APPEND: begin
                if (stored_count < nvs_pkg::MAX_VERTICES) begin
                    stored_x[stored_count] = px;
                    stored_y[stored_count] = py;
                    stored_z[stored_count] = pz;
                    stored_count++;
                end else begin
                    dropped_flag = 1'b1;
                end
            end
            nvs_pkg::REQ_QUERY: begin
                best = 0;
                best_i = 0;
                for (int i = 0; i < stored_count; i++) begin
                    dx = longint'(stored_x[i]) - longint'(px);
                    dy = longint'(stored_y[i]) - longint'(py);
                    dz = longint'(stored_z[i]) - longint'(pz);
                    d = dx * dx + dy * dy + dz * dz;
                    // Strictly smaller only, so the earliest minimum is kept.
                    if (i == 0 || d < best) begin
                        best = d;
                        best_i = i;
                    end
                end
                ans.near_idx  = best_i[nvs_pkg::IDX_OUT_W-1:0];
                ans.distance  = best[nvs_pkg::DIST_OUT_W-1:0];
                ans.was_empty = (stored_count == 0);
                ans.had_drop  = dropped_flag;
                pending_answers.insert(pending_answers.size(), ans);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_request(input logic [1:0] req, input logic [15:0] x,
                                input logic [15:0] y, input logic [15:0] z);
        while (!calm && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_request(req, x, y, z);
    endtask

    task automatic wait_for_answers();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return 16'h8000;
        if (pick < 16) return 16'h7FFF;
        if (pick < 30) return 16'($urandom_range(0, 511)) - 16'd256;
        return 16'($urandom);
    endfunction

    task automatic test_extremes();
        send_request(nvs_pkg::REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);
        send_request(nvs_pkg::REQ_QUERY, 16'h7FFF, 16'h8000, 16'h5555);
        send_request(nvs_pkg::REQ_APPEND, 16'h8000, 16'h8000, 16'h8000);
        // Opposite corner of the coordinate cube gives the largest distance.
        send_request(nvs_pkg::REQ_QUERY, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_request(nvs_pkg::REQ_APPEND, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_request(nvs_pkg::REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);
        send_request(nvs_pkg::REQ_QUERY, 16'h8000, 16'h8000, 16'h8000);
        send_request(nvs_pkg::REQ_APPEND, 16'h5555, 16'hAAAA, 16'h5555);
        send_request(nvs_pkg::REQ_QUERY, 16'hAAAA, 16'h5555, 16'hAAAA);
        wait_for_answers();
    endtask

    task automatic test_ties_and_ignored();
        send_request(nvs_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(nvs_pkg::REQ_QUERY, 16'h1234, 16'h0000, 16'hFFFF);
        send_request(nvs_pkg::REQ_APPEND, 16'h0100, 16'h0000, 16'h0000);
        send_request(nvs_pkg::REQ_APPEND, 16'hFF00, 16'h0000, 16'h0000);
        send_request(nvs_pkg::REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);
        send_request(nvs_pkg::REQ_APPEND, 16'h0100, 16'h0000, 16'h0000);
        send_request(nvs_pkg::REQ_QUERY, 16'h0100, 16'h0000, 16'h0000);
        // An unused request type must leave the store as it was.
        send_request(REQ_UNUSED, 16'hAAAA, 16'h5555, 16'hFFFF);
        send_request(nvs_pkg::REQ_QUERY, 16'hFF00, 16'h0000, 16'h0000);
        send_request(nvs_pkg::REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);
        wait_for_answers();
    endtask

    task automatic test_output_stall();
        send_request(nvs_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000);
        repeat (6) begin
            send_request(nvs_pkg::REQ_APPEND, rand_coord(), rand_coord(), rand_coord());
        end
        hold_asked++;
        // Queries keep coming while the result side is held off.
        repeat (12) begin
            send_request(nvs_pkg::REQ_QUERY, rand_coord(), rand_coord(), rand_coord());
        end
        wait_for_answers();
    endtask

    task automatic test_full_store();
        send_request(nvs_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000);
        repeat (nvs_pkg::MAX_VERTICES) begin
            send_request(nvs_pkg::REQ_APPEND, rand_coord(), rand_coord(), rand_coord());
        end
        send_request(nvs_pkg::REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);
        repeat (3) begin
            send_request(nvs_pkg::REQ_APPEND, rand_coord(), rand_coord(), rand_coord());
        end
        send_request(nvs_pkg::REQ_QUERY, stored_x[nvs_pkg::MAX_VERTICES-1],
                     stored_y[nvs_pkg::MAX_VERTICES-1], stored_z[nvs_pkg::MAX_VERTICES-1]);
        send_request(nvs_pkg::REQ_QUERY, stored_x[nvs_pkg::MAX_VERTICES/2],
                     stored_y[nvs_pkg::MAX_VERTICES/2], stored_z[nvs_pkg::MAX_VERTICES/2]);
        send_request(nvs_pkg::REQ_QUERY, 16'h7FFF, 16'h8000, 16'h7FFF);
        repeat (2) begin
            send_request(nvs_pkg::REQ_QUERY, rand_coord(), rand_coord(), rand_coord());
        end
        send_request(nvs_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000);
        send_request(nvs_pkg::REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);
        send_request(nvs_pkg::REQ_APPEND, rand_coord(), rand_coord(), rand_coord());
        send_request(nvs_pkg::REQ_QUERY, rand_coord(), rand_coord(), rand_coord());
        wait_for_answers();
    endtask

    task automatic test_random_sessions();
        int          counted;
        int          cap;
        int          pick;
        int          j;
        int          spread;
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
        counted = 0;
        cap = 8;
        send_request(nvs_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        while (counted < RANDOM_ITEMS) begin
            calm = (counted >= 220 && counted < 370);
            pick = $urandom_range(0, 99);
            if (stored_count > 0 && $urandom_range(0, 1) == 1) begin
                // A point on or close to a stored vertex, which makes ties likely.
                j = $urandom_range(0, stored_count - 1);
                spread = $urandom_range(0, 1) ? 0 : 4;
                qx = stored_x[j] + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
                qy = stored_y[j] + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
                qz = stored_z[j] + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
            end else begin
                qx = rand_coord();
                qy = rand_coord();
                qz = rand_coord();
            end
            if (pick < 5) begin
                send_request(nvs_pkg::REQ_CLEAR, qx, qy, qz);
                cap = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 96)
                                                  : $urandom_range(1, 16);
            end else if (pick < 8) begin
                send_request(REQ_UNUSED, qx, qy, qz);
                continue;
            end else if (pick < 50 && stored_count < cap) begin
                send_request(nvs_pkg::REQ_APPEND, qx, qy, qz);
            end else begin
                send_request(nvs_pkg::REQ_QUERY, qx, qy, qz);
            end
            counted++;
        end
        calm = 1'b0;
        wait_for_answers();
    endtask

    // Result side: random stalls, plus a long hold-off when a test asks for one.
    always @(posedge clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 12);
        end
    end

    always @(posedge clk) begin : check_output
        t_answer want;
        if (rst_n && m_axis_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result transfer with no query pending", 1, 0);
            end else begin
                want = pending_answers.pop_front();
                if (m_axis_tdata[9:0] !== want.near_idx)
                    report_mismatch("closest_index", m_axis_tdata[9:0], want.near_idx);
                if (m_axis_tdata[43:10] !== want.distance)
                    report_mismatch("best_distance", m_axis_tdata[43:10], want.distance);
                if (m_axis_tdata[47:44] !== 4'd0)
                    report_mismatch("tdata padding", m_axis_tdata[47:44], 0);
                if (m_axis_tuser[0] !== want.was_empty)
                    report_mismatch("store_empty", m_axis_tuser[0], want.was_empty);
                if (m_axis_tuser[1] !== want.had_drop)
                    report_mismatch("store_overflowed", m_axis_tuser[1], want.had_drop);
            end
        end
    end

    // Ends the run when no transfer happens on either side for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_ties_and_ignored();
        test_output_stall();
        test_full_store();
        test_random_sessions();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
